// File: design/lchh_pkg.sv
// package for the lossy counting heavy hitter table
// types, codes and defaults shared by the interfaces, the front, the back and the top level
// no dependencies
package lchh_pkg;

	// default table geometry
	localparam int SETS_DEF      = 256;
	localparam int WAYS_DEF      = 4;
	localparam int FLOW_BITS_DEF = 64;

	// fixed field widths
	localparam int CMD_W    = 2;
	localparam int BIDX_W   = 8;
	localparam int FLOW_W   = 64;
	localparam int COUNT_W  = 16;
	localparam int STATUS_W = 2;
	localparam int WORD_W   = 32;
	localparam int OCC_W    = 11;
	localparam int SET_MAX_W = 12;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_DATA_W-1:0] BUCKET_WIDTH_RST    = 16'd100;
	localparam logic [CFG_DATA_W-1:0] REPORT_FRACTION_RST = 16'd655;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BUCKET_WIDTH    = 1'd0,
		CFG_REPORT_FRACTION = 1'd1
	} cfg_idx_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_UPDATE = 2'd0,
		CMD_QUERY  = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE   = 2'd0,
		STAT_PRUNED = 2'd1,
		STAT_FULL   = 2'd2,
		STAT_MISS   = 2'd3
	} status_t;

	// classified operation handed from front to back
	typedef struct packed {
		cmd_t                 cmd;
		logic [SET_MAX_W-1:0] set;
		logic [FLOW_W-1:0]    flow;
		logic [COUNT_W-1:0]   count;
	} op_t;

	// queue head seen by the back
	typedef struct packed {
		logic valid;
		op_t  op;
	} op_head_t;

endpackage

// File: design/lchh_if.sv
// valid/ready channel interfaces for items in and results out
// depends on lchh_pkg for field widths
interface lchh_in_if;
	logic                          valid;
	logic                          ready;
	logic [lchh_pkg::CMD_W-1:0]    cmd;
	logic [lchh_pkg::BIDX_W-1:0]   bucket_index;
	logic [lchh_pkg::FLOW_W-1:0]   flow_id;
	logic [lchh_pkg::COUNT_W-1:0]  count;

	modport source (output valid, cmd, bucket_index, flow_id, count, input ready);
	modport sink   (input valid, cmd, bucket_index, flow_id, count, output ready);
endinterface

interface lchh_out_if;
	logic                          valid;
	logic                          ready;
	logic [lchh_pkg::STATUS_W-1:0] status;
	logic                          heavy;
	logic [lchh_pkg::WORD_W-1:0]   frequency;
	logic [lchh_pkg::WORD_W-1:0]   error_bound;
	logic [lchh_pkg::OCC_W-1:0]    occupancy;

	modport source (output valid, status, heavy, frequency, error_bound, occupancy, input ready);
	modport sink   (input valid, status, heavy, frequency, error_bound, occupancy, output ready);
endinterface

// File: design/lchh_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module lchh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: design/lchh_front.sv
// front: accepts items, classifies them and holds them in a two entry queue
// depends on lchh_pkg and lchh_if
module lchh_front #(
	parameter int SETS      = lchh_pkg::SETS_DEF,
	parameter int FLOW_BITS = lchh_pkg::FLOW_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	lchh_in_if.sink            in_ch,
	output lchh_pkg::op_head_t head,
	input  logic               pop
);
	import lchh_pkg::*;

	typedef logic [SET_MAX_W-1:0] set_lut_t [256];

	function automatic set_lut_t build_lut();
		set_lut_t lut;
		for (int i = 0; i < 256; i++) begin
			lut[i] = SET_MAX_W'(i % SETS);
		end
		return lut;
	endfunction

	localparam set_lut_t SET_LUT = build_lut();
	localparam logic [FLOW_W-1:0] FLOW_MASK = {FLOW_W{1'b1}} >> (FLOW_W - FLOW_BITS);

	op_t        slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	op_t        op_in;
	logic       push;

	// classify the incoming item
	always_comb begin
		op_in.cmd   = cmd_t'(in_ch.cmd);
		op_in.set   = SET_LUT[in_ch.bucket_index];
		op_in.flow  = in_ch.flow_id & FLOW_MASK;
		op_in.count = in_ch.count;
	end

	assign in_ch.ready = (fill_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign head.valid  = (fill_q != 2'd0);
	assign head.op     = slot_q[rd_ptr_q];

	// queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= op_in;
		end
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

`ifndef ASSERT_OFF
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid) else $error("pop from empty queue");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == 2'd2 |=> fill_q != 2'd0 || $past(pop)) else $error("queue fill jumped");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3) else $error("queue overfilled");
`endif
endmodule

// File: design/lchh_back.sv
// back: set lookup, insert, delete, counters, bucket prune walk and result register
// depends on lchh_pkg, lchh_if and lchh_ram
module lchh_back #(
	parameter int SETS      = lchh_pkg::SETS_DEF,
	parameter int WAYS      = lchh_pkg::WAYS_DEF,
	parameter int FLOW_BITS = lchh_pkg::FLOW_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lchh_pkg::op_head_t                head,
	output logic                              pop,
	input  logic                              cfg_we,
	input  logic [lchh_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lchh_pkg::CFG_DATA_W-1:0]   cfg_data,
	lchh_out_if.source                        out_ch
);
	import lchh_pkg::*;

	localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int EW     = 1 + FLOW_BITS + 2 * WORD_W;
	localparam int ROW_W  = WAYS * EW;
	localparam int TOTAL  = SETS * WAYS;
	localparam int CNT_W  = $clog2(TOTAL + 1);
	localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);
	localparam logic [WORD_W-1:0] MAX_WORD = {WORD_W{1'b1}};

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_EVAL  = 7'b0000100,
		S_PR_RD = 7'b0001000,
		S_PR_WR = 7'b0010000,
		S_MUL   = 7'b0100000,
		S_RESP  = 7'b1000000
	} state_t;

	function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WORD_W] ? MAX_WORD : s[WORD_W-1:0];
	endfunction

	state_t                  state_q;
	logic [SET_W-1:0]        ptr_q;
	op_t                     op_q;
	logic [WORD_W-1:0]       cur_q, in_bkt_q, total_q;
	logic [CNT_W-1:0]        vcount_q;
	logic [CFG_DATA_W-1:0]   bw_q, rf_q;
	status_t                 res_status_q;
	logic [WORD_W-1:0]       res_f_q, res_d_q;
	logic                    need_heavy_q, prune_q;
	logic [CFG_DATA_W+WORD_W-1:0] prod_q;
	logic                    out_valid_q;
	status_t                 out_status_q;
	logic                    out_heavy_q;
	logic [WORD_W-1:0]       out_f_q, out_d_q;
	logic [OCC_W-1:0]        out_occ_q;

	logic                    ram_we;
	logic [SET_W-1:0]        ram_waddr, ram_raddr;
	logic [ROW_W-1:0]        ram_wdata, rd_row, pr_row;
	logic                    hit, free;
	logic [WAY_W-1:0]        hit_way, free_way;
	logic [EW-1:0]           hit_ent;
	logic [FLOW_BITS-1:0]    op_flow;
	logic [CNT_W-1:0]        pruned_n;
	logic                    out_free;

	lchh_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_row)
	);

	assign op_flow  = op_q.flow[FLOW_BITS-1:0];
	assign pop      = (state_q == S_IDLE) && head.valid;
	assign out_free = !out_valid_q || out_ch.ready;

	// way match and lowest free way in the row just read
	always_comb begin
		hit      = 1'b0;
		free     = 1'b0;
		hit_way  = '0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (rd_row[w*EW + EW - 1] &&
			    rd_row[w*EW + 2*WORD_W +: FLOW_BITS] == op_flow) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!rd_row[w*EW + EW - 1]) begin
				free     = 1'b1;
				free_way = WAY_W'(w);
			end
		end
		hit_ent = rd_row[hit_way*EW +: EW];
	end

	// prune of one row against the current bucket number
	always_comb begin
		pr_row   = rd_row;
		pruned_n = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (rd_row[w*EW + EW - 1] &&
			    ({1'b0, rd_row[w*EW + WORD_W +: WORD_W]} + {1'b0, rd_row[w*EW +: WORD_W]}
			     <= {1'b0, cur_q})) begin
				pr_row[w*EW + EW - 1] = 1'b0;
				pruned_n = pruned_n + CNT_W'(1);
			end
		end
	end

	// ram port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = rd_row;
		ram_raddr = head.op.set[SET_W-1:0];
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			S_EVAL: begin
				ram_waddr = op_q.set[SET_W-1:0];
				unique case (op_q.cmd)
					CMD_UPDATE: begin
						if (hit) begin
							ram_we = 1'b1;
							ram_wdata[hit_way*EW +: EW] = {1'b1, op_flow,
								sat_add(hit_ent[WORD_W +: WORD_W], WORD_W'(op_q.count)),
								hit_ent[WORD_W-1:0]};
						end else if (free) begin
							ram_we = 1'b1;
							ram_wdata[free_way*EW +: EW] = {1'b1, op_flow,
								WORD_W'(op_q.count), cur_q - WORD_W'(1)};
						end
					end
					CMD_DELETE: begin
						if (hit) begin
							ram_we = 1'b1;
							ram_wdata[hit_way*EW + EW - 1] = 1'b0;
						end
					end
					CMD_QUERY, CMD_NOP: begin
						ram_we = 1'b0;
					end
					default: ram_we = 1'b0;
				endcase
			end
			S_PR_RD: begin
				ram_raddr = ptr_q;
			end
			S_PR_WR: begin
				ram_we    = 1'b1;
				ram_wdata = pr_row;
			end
			S_IDLE, S_MUL, S_RESP: begin
				ram_we = 1'b0;
			end
			default: ram_we = 1'b0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q <= BUCKET_WIDTH_RST;
			rf_q <= REPORT_FRACTION_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BUCKET_WIDTH:    bw_q <= cfg_data;
				CFG_REPORT_FRACTION: rf_q <= cfg_data;
				default:             bw_q <= bw_q;
			endcase
		end
	end

	// result payload working registers
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= head.op;
		end
		unique case (state_q)
			S_EVAL: begin
				unique case (op_q.cmd)
					CMD_UPDATE: begin
						if (hit) begin
							res_status_q <= STAT_DONE;
							res_f_q      <= sat_add(hit_ent[WORD_W +: WORD_W],
								WORD_W'(op_q.count));
							res_d_q      <= hit_ent[WORD_W-1:0];
							need_heavy_q <= 1'b1;
						end else if (free) begin
							res_status_q <= STAT_DONE;
							res_f_q      <= WORD_W'(op_q.count);
							res_d_q      <= cur_q - WORD_W'(1);
							need_heavy_q <= 1'b1;
						end else begin
							res_status_q <= STAT_FULL;
							res_f_q      <= '0;
							res_d_q      <= '0;
							need_heavy_q <= 1'b0;
						end
					end
					CMD_QUERY, CMD_DELETE: begin
						if (hit) begin
							res_status_q <= STAT_DONE;
							res_f_q      <= hit_ent[WORD_W +: WORD_W];
							res_d_q      <= hit_ent[WORD_W-1:0];
							need_heavy_q <= (op_q.cmd == CMD_QUERY);
						end else begin
							res_status_q <= STAT_MISS;
							res_f_q      <= '0;
							res_d_q      <= '0;
							need_heavy_q <= 1'b0;
						end
					end
					default: begin
						res_status_q <= STAT_MISS;
						res_f_q      <= '0;
						res_d_q      <= '0;
						need_heavy_q <= 1'b0;
					end
				endcase
			end
			S_MUL: begin
				prod_q <= rf_q * total_q;
				// entry removed by the prune reads as absent
				if (prune_q && ({1'b0, res_f_q} + {1'b0, res_d_q} <= {1'b0, cur_q})) begin
					res_f_q      <= '0;
					res_d_q      <= '0;
					need_heavy_q <= 1'b0;
				end
				if (prune_q) begin
					res_status_q <= STAT_PRUNED;
				end
			end
			default: prod_q <= prod_q;
		endcase
		if (state_q == S_RESP && out_free) begin
			out_status_q <= res_status_q;
			out_heavy_q  <= need_heavy_q && ({res_f_q, 16'b0} > prod_q);
			out_f_q      <= res_f_q;
			out_d_q      <= res_d_q;
			out_occ_q    <= (vcount_q > CNT_W'(2047)) ? OCC_W'(2047) : OCC_W'(vcount_q);
		end
	end

	// sequencer, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			ptr_q       <= '0;
			cur_q       <= WORD_W'(1);
			in_bkt_q    <= '0;
			total_q     <= '0;
			vcount_q    <= '0;
			prune_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// output valid: set by a new result, cleared once taken
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (ptr_q == LAST_SET) begin
						ptr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + SET_W'(1);
					end
				end
				S_IDLE: begin
					prune_q <= 1'b0;
					if (head.valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (op_q.cmd == CMD_UPDATE && (hit || free)) begin
						logic [WORD_W-1:0] in_new;
						logic [WORD_W-1:0] bw_eff;
						in_new  = sat_add(in_bkt_q, WORD_W'(op_q.count));
						bw_eff  = (bw_q == '0) ? WORD_W'(1) : WORD_W'(bw_q);
						total_q <= sat_add(total_q, WORD_W'(op_q.count));
						if (!hit) begin
							vcount_q <= vcount_q + CNT_W'(1);
						end
						if (in_new >= bw_eff) begin
							in_bkt_q <= in_new - bw_eff;
							cur_q    <= sat_add(cur_q, WORD_W'(1));
							prune_q  <= 1'b1;
							ptr_q    <= '0;
							state_q  <= S_PR_RD;
						end else begin
							in_bkt_q <= in_new;
							state_q  <= S_MUL;
						end
					end else if (op_q.cmd == CMD_DELETE && hit) begin
						vcount_q <= vcount_q - CNT_W'(1);
						state_q  <= S_MUL;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_PR_RD: state_q <= S_PR_WR;
				S_PR_WR: begin
					vcount_q <= vcount_q - pruned_n;
					if (ptr_q == LAST_SET) begin
						ptr_q   <= '0;
						state_q <= S_MUL;
					end else begin
						ptr_q   <= ptr_q + SET_W'(1);
						state_q <= S_PR_RD;
					end
				end
				S_MUL: state_q <= S_RESP;
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = out_status_q;
	assign out_ch.heavy       = out_heavy_q;
	assign out_ch.frequency   = out_f_q;
	assign out_ch.error_bound = out_d_q;
	assign out_ch.occupancy   = out_occ_q;

`ifndef ASSERT_OFF
	a_vcount_range: assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q <= CNT_W'(TOTAL)) else $error("valid count above table size");
	a_valid_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESP)) else $error("result without resp");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == S_EVAL) else $error("pop did not start lookup");
	a_bucket_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q != '0) else $error("bucket number zero");
`endif
endmodule

// File: design/lossy_counting_heavy_hitter_table.sv
// top level of the lossy counting heavy hitter table
// depends on lchh_pkg, lchh_if, lchh_front, lchh_back and lchh_ram
//
// channel   dir  handshake    payload
// in_ch     in   valid/ready  cmd, bucket_index, flow_id, count
// out_ch    out  valid/ready  status, heavy, frequency, error_bound, occupancy
// cfg       in   cfg_we       cfg_index, cfg_data
//
// an item passes through the back as row read, evaluate and write, multiply and result, in that order
// an update that crosses a bucket boundary adds a prune walk that reads and rewrites every ram row
// after reset a clearing pass zeroes every ram row before the first item is served
// a two entry queue lets the front keep taking items while the back works or the output stalls
module lossy_counting_heavy_hitter_table #(
	parameter int SETS      = lchh_pkg::SETS_DEF,
	parameter int WAYS      = lchh_pkg::WAYS_DEF,
	parameter int FLOW_BITS = lchh_pkg::FLOW_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	lchh_in_if.sink                         in_ch,
	lchh_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [lchh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lchh_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lchh_pkg::*;

	op_head_t head;
	logic     pop;

	// front: accept and classify
	lchh_front #(.SETS(SETS), .FLOW_BITS(FLOW_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.head   (head),
		.pop    (pop)
	);

	// back: table work and result register
	lchh_back #(.SETS(SETS), .WAYS(WAYS), .FLOW_BITS(FLOW_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ch    (out_ch)
	);
endmodule
